// ===== hdl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and byte codes of the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam logic [7:0] BYTE_EOT   = 8'd4;
  localparam logic [7:0] BYTE_BS    = 8'd8;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [5:0] MAX_LINE_RST = 6'd32;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_ERASE,
    OP_EOL,
    OP_EOT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } cmd_t;

endpackage

// ===== hdl/cle_if.sv =====
// ----------------------------------------------------------------------------
// cle_rx_if / cle_res_if
// Valid/ready channels for received bytes and editor results.
// ----------------------------------------------------------------------------
interface cle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cle_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

// ===== hdl/cle_front.sv =====
// ----------------------------------------------------------------------------
// cle_front
// Accepts received bytes, classifies them and queues commands (two deep).
// ----------------------------------------------------------------------------
module cle_front
  import cle_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  cle_rx_if.sink   rx_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_ready_i
);

  cmd_t head_q, tail_q, in_cmd;
  logic head_v_q, tail_v_q;
  logic push, pop;

  always_comb begin
    in_cmd.ch = rx_i.rx_byte;
    case (rx_i.rx_byte)
      BYTE_EOT:         in_cmd.op = OP_EOT;
      BYTE_BS:          in_cmd.op = OP_ERASE;
      BYTE_CR, BYTE_LF: in_cmd.op = OP_EOL;
      default:          in_cmd.op = OP_CHAR;
    endcase
  end

  // tail slot only fills behind a stalled head, so a free tail means room
  assign rx_i.ready  = !tail_v_q;
  assign push        = rx_i.valid && !tail_v_q;
  assign pop         = head_v_q && cmd_ready_i;
  assign cmd_valid_o = head_v_q;
  assign cmd_o       = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else if (pop) begin
      if (tail_v_q) begin
        head_q   <= tail_q;
        tail_v_q <= 1'b0;
      end else begin
        head_v_q <= push;
        head_q   <= in_cmd;
      end
    end else if (push) begin
      if (head_v_q) begin
        tail_q   <= in_cmd;
        tail_v_q <= 1'b1;
      end else begin
        head_q   <= in_cmd;
        head_v_q <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/cle_back.sv =====
// ----------------------------------------------------------------------------
// cle_back
// Executes queued commands: line store, character count, result sequencing.
// ----------------------------------------------------------------------------
module cle_back
  import cle_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [5:0] max_line_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_ready_o,
  cle_res_if.source  res_o
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam int LW = ((CW > 6) ? CW : 6) + 1;
  localparam logic [LW-1:0] CAP_L = LW'(LINE_CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPACE,
    S_BS2,
    S_LF,
    S_LINE
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      kind_q, kind_d;
  logic [7:0]      data_q, data_d;
  logic            last_q, last_d;
  logic [7:0]      rd_q;
  logic [7:0]      mem [LINE_CAPACITY];
  logic            we;
  logic [7:0]      wdata;
  logic            can_load;
  logic [LW-1:0]   lim;
  logic            line_end;

  assign can_load = !out_valid_q || res_o.ready;
  assign lim      = (LW'(max_line_i) > CAP_L) ? CAP_L : LW'(max_line_i);
  assign line_end = (ptr_q + CW'(1)) == count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !res_o.ready;
    kind_d      = kind_q;
    data_d      = data_q;
    last_d      = last_q;
    cmd_ready_o = 1'b0;
    we          = 1'b0;
    wdata       = cmd_i.ch;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && can_load) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.op)
            OP_CHAR: begin
              if (LW'(count_q) + LW'(1) < lim) begin
                we          = 1'b1;
                count_d     = count_q + CW'(1);
                out_valid_d = 1'b1;
                kind_d      = KIND_ECHO;
                data_d      = cmd_i.ch;
                last_d      = 1'b1;
              end
            end
            OP_ERASE: begin
              if (count_q != '0) begin
                count_d     = count_q - CW'(1);
                out_valid_d = 1'b1;
                kind_d      = KIND_ECHO;
                data_d      = BYTE_BS;
                last_d      = 1'b0;
                state_d     = S_SPACE;
              end
            end
            OP_EOL: begin
              we          = 1'b1;
              wdata       = BYTE_LF;
              count_d     = count_q + CW'(1);
              out_valid_d = 1'b1;
              kind_d      = KIND_ECHO;
              data_d      = BYTE_CR;
              last_d      = 1'b0;
              state_d     = S_LF;
            end
            OP_EOT: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                kind_d      = KIND_EMPTY;
                data_d      = 8'd0;
                last_d      = 1'b1;
              end else begin
                state_d = S_LINE;
              end
            end
            default: ;
          endcase
        end
      end
      S_SPACE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ECHO;
          data_d      = BYTE_SPACE;
          last_d      = 1'b0;
          state_d     = S_BS2;
        end
      end
      S_BS2: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ECHO;
          data_d      = BYTE_BS;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_LF: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ECHO;
          data_d      = BYTE_LF;
          last_d      = 1'b0;
          state_d     = S_LINE;
        end
      end
      S_LINE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_LINE;
          data_d      = rd_q;
          last_d      = line_end;
          ptr_d       = ptr_q + CW'(1);
          if (line_end) begin
            ptr_d   = '0;
            count_d = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      data_q      <= data_d;
      last_q      <= last_d;
    end
  end

  // read follows the next pointer so rd_q matches ptr_q each cycle;
  // any write lands in the store before the line is read out
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[count_q[AW-1:0]] <= wdata;
    end
    rd_q <= mem[ptr_d[AW-1:0]];
  end

  assign res_o.valid = out_valid_q;
  assign res_o.kind  = kind_q;
  assign res_o.data  = data_q;
  assign res_o.last  = last_q;

endmodule

// ===== hdl/console_line_editor.sv =====
// ----------------------------------------------------------------------------
// console_line_editor
// Canonical-mode line editor: echo, erase, line hand-out on CR/LF or EOT.
// ----------------------------------------------------------------------------
//  channel  dir  payload                 handshake
//  rx_i     in   rx_byte[7:0]            valid/ready
//  res_o    out  kind[1:0] data[7:0] last valid/ready
//  cfg      in   cfg_wdata_i[5:0]        cfg_we_i, no stall
//
// One result leaves the output register per cycle while res_o is ready; the back
// end's sequencer sets the pace: an ordinary byte gives one echo, an erase the
// BS/space/BS echo, CR/LF the CR and LF echoes and the stored line, EOT the line.
// Reset clears the count and control state; the line store is not cleared.
// A two-deep command queue accepts bytes while results stall, until it is full.
// ----------------------------------------------------------------------------
module console_line_editor
  import cle_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  cle_rx_if.sink     rx_i,
  cle_res_if.source  res_o
);

  logic [5:0] max_line_q;
  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= MAX_LINE_RST;
    end else if (cfg_we_i) begin
      max_line_q <= cfg_wdata_i;
    end
  end

  cle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  cle_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_line_i  (max_line_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_o       (res_o)
  );

  // queued command holds while the back end is busy
  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("queued command changed while stalled");

  // stalled result beat stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid)
    else $error("result beat dropped while stalled");

  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == KIND_EMPTY |-> res_o.last && res_o.data == 8'd0)
    else $error("empty line end malformed");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.kind == KIND_ECHO || res_o.kind == KIND_LINE ||
                     res_o.kind == KIND_EMPTY))
    else $error("undefined result kind");

endmodule

// ===== tb/tb_console_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_line_editor
// Self-checking bench for the console line editor. A queue-fed driver sends
// received bytes in random bursts while the result side stalls on a rotating
// pattern. Every accepted byte runs through an in-bench line editor model and
// the result beats it predicts are checked in order against the block's
// output. Directed bytes cover erase, line ends, end of transmission, full
// lines and a lowered limit mid-line; random sessions follow for several
// max_line settings.
// ----------------------------------------------------------------------------
module tb_console_line_editor;
  import cle_pkg::*;

  localparam int LINE_CAP       = 32;
  localparam int DRAIN_CYCLES   = 40;   // longest result train plus margin
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [5:0] cfg_wdata_i;

  cle_rx_if  rx_if ();
  cle_res_if res_if ();

  console_line_editor #(
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- editor model
  logic [7:0]  line_buf [LINE_CAP];
  int unsigned line_len;
  logic [5:0]  max_line_cfg;
  res_beat_t   res_due_q[$];

  // stimulus / pacing
  logic [7:0]  rx_pending_q[$];
  int unsigned gap_max;
  logic [15:0] ready_pat;

  // bookkeeping
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned rx_beats;
  int unsigned res_beats;
  int unsigned lines_out;
  int unsigned cfg_writes;
  int unsigned op_hits [4];

  function automatic op_e decode_op(logic [7:0] b);
    case (b)
      BYTE_EOT:         return OP_EOT;
      BYTE_BS:          return OP_ERASE;
      BYTE_CR, BYTE_LF: return OP_EOL;
      default:          return OP_CHAR;
    endcase
  endfunction

  function void due(logic [1:0] kind, logic [7:0] data, logic last);
    res_due_q.push_back('{kind: kind, data: data, last: last});
  endfunction

  // hand out the stored line, or the empty-line marker
  function void hand_out_line();
    if (line_len == 0) begin
      due(KIND_EMPTY, 8'h00, 1'b1);
    end else begin
      for (int unsigned i = 0; i < line_len; i++)
        due(KIND_LINE, line_buf[i], (i + 1 == line_len));
    end
    line_len = 0;
  endfunction

  function void apply_rx_byte(logic [7:0] b);
    int unsigned limit;
    op_e op;
    limit = (max_line_cfg < LINE_CAP) ? max_line_cfg : LINE_CAP;
    op = decode_op(b);
    op_hits[op]++;
    case (op)
      OP_EOT: begin
        hand_out_line();
      end
      OP_ERASE: begin
        if (line_len != 0) begin
          line_len--;
          due(KIND_ECHO, BYTE_BS, 1'b0);
          due(KIND_ECHO, BYTE_SPACE, 1'b0);
          due(KIND_ECHO, BYTE_BS, 1'b1);
        end
      end
      OP_EOL: begin
        if (line_len < LINE_CAP) begin
          line_buf[line_len] = BYTE_LF;
          line_len++;
        end
        due(KIND_ECHO, BYTE_CR, 1'b0);
        due(KIND_ECHO, BYTE_LF, 1'b0);
        hand_out_line();
      end
      default: begin
        // full line: dropped silently
        if (line_len + 1 < limit && line_len < LINE_CAP) begin
          line_buf[line_len] = b;
          line_len++;
          due(KIND_ECHO, b, 1'b1);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- driver
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= 8'h00;
      burst_left    <= 1;
      gap_left      <= 0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (gap_left != 0) begin
        rx_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (rx_pending_q.size() != 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= rx_pending_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // result side stalls on a rotating pattern
  logic [3:0] pat_idx;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      pat_idx      <= '0;
    end else begin
      res_if.ready <= ready_pat[pat_idx];
      pat_idx      <= pat_idx + 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        res_beats++;
        if (res_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] unexpected beat: kind %0d data %02h last %0d", $realtime,
                     res_if.kind, res_if.data, res_if.last);
        end else begin
          res_beat_t exp_b;
          exp_b = res_due_q.pop_front();
          if (exp_b.last && exp_b.kind != KIND_ECHO) lines_out++;
          if (res_if.kind !== exp_b.kind || res_if.data !== exp_b.data ||
              res_if.last !== exp_b.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("[%0t] mismatch: expected kind %0d data %02h last %0d, got kind %0d data %02h last %0d",
                       $realtime, exp_b.kind, exp_b.data, exp_b.last,
                       res_if.kind, res_if.data, res_if.last);
          end
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        rx_beats++;
        apply_rx_byte(rx_if.rx_byte);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      idle_cycles <= 0;
    else if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------- stimulus
  // wait for every byte to be taken and every result to arrive, then let the
  // block finish any byte that produced nothing
  task automatic settle();
    while (rx_pending_q.size() != 0 || rx_if.valid || res_due_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_max_line(logic [5:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_line_cfg = value;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic set_pacing(bit steady);
    if (steady) begin
      gap_max   = 0;
      ready_pat = 16'hffff;
    end else begin
      gap_max   = ($urandom_range(0, 3) == 0) ? 12 : 3;
      ready_pat = 16'($urandom()) | 16'h0001;
    end
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (decode_op(b) != OP_CHAR);
    return b;
  endfunction

  // mostly well-formed lines with random text and erases, some raw noise
  task automatic queue_session(int unsigned n_items);
    int unsigned n;
    int unsigned len;
    int unsigned pick;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        rx_pending_q.push_back(8'($urandom_range(0, 255)));
        n++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        for (int unsigned i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            rx_pending_q.push_back(BYTE_BS);
            n++;
          end
          rx_pending_q.push_back(plain_char());
          n++;
        end
        pick = $urandom_range(0, 2);
        rx_pending_q.push_back(pick == 0 ? BYTE_CR : pick == 1 ? BYTE_LF : BYTE_EOT);
        n++;
      end
    end
  endtask

  task automatic run_stimulus();
    logic [5:0] settings [8];
    settings = '{6'd63, 6'd32, 6'd1, 6'd0, 6'd2, 6'($urandom_range(3, 30)), 6'd31,
                 6'($urandom_range(0, 63))};
    @(negedge clk_i);
    set_pacing(1'b0);

    // extremes, erase down to an empty line, empty lines, EOT with text
    rx_pending_q = '{8'h41, 8'h00, 8'hff, BYTE_BS, BYTE_BS, BYTE_BS, BYTE_CR, BYTE_EOT,
                     8'h68, 8'h69, BYTE_EOT, 8'h7f, 8'h80, BYTE_LF,
                     8'h70, 8'h71, 8'h72};
    settle();
    // limit lowered with three characters pending: the next character is dropped
    write_max_line(6'd2);
    rx_pending_q = '{8'h73, BYTE_EOT, 8'h61, 8'h62, BYTE_CR};
    settle();
    write_max_line(6'd0);
    rx_pending_q = '{8'h7a, BYTE_BS, BYTE_LF};
    settle();

    foreach (settings[p]) begin
      write_max_line(settings[p]);
      set_pacing(p % 3 == 1);
      queue_session(50);
      settle();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready  = 1'b0;
    ready_pat     = 16'hffff;
    gap_max       = 0;
    max_line_cfg  = MAX_LINE_RST;
    line_len      = 0;
    mismatches    = 0;
    rx_beats      = 0;
    res_beats     = 0;
    lines_out     = 0;
    cfg_writes    = 0;
    foreach (op_hits[i]) op_hits[i] = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      run_stimulus();
      wait (idle_cycles >= WATCHDOG_LIMIT);
    join_any
    disable fork;

    if (idle_cycles >= WATCHDOG_LIMIT)
      $display("watchdog: no beat for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, res_due_q.size());
    $display("sent %0d bytes (%0d text, %0d erase, %0d line end, %0d eot) over %0d max_line writes",
             rx_beats, op_hits[OP_CHAR], op_hits[OP_ERASE], op_hits[OP_EOL], op_hits[OP_EOT],
             cfg_writes);
    $display("checked %0d result beats, %0d lines handed out, %0d mismatches",
             res_beats, lines_out, mismatches);
    if (idle_cycles < WATCHDOG_LIMIT && mismatches == 0 && res_due_q.size() == 0) begin
      $display("console_line_editor regression: pass");
    end else begin
      $display("console_line_editor regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cle_pkg.sv
hdl/cle_if.sv
hdl/cle_front.sv
hdl/cle_back.sv
hdl/console_line_editor.sv
tb/tb_console_line_editor.sv
